### src/jfsp_pkg.sv
// ---------------------------------------------------------------------------
// jfsp_pkg
// shared types and constants for the jpeg frame size parser
// ---------------------------------------------------------------------------
package jfsp_pkg;

    localparam logic [7:0] MARK_LEAD    = 8'hFF;
    localparam logic [7:0] MARK_SOI     = 8'hD8;
    localparam logic [7:0] SOF_LOW      = 8'hC0;
    localparam logic [7:0] SOF_HIGH     = 8'hCF;
    localparam logic [7:0] MARK_DHT     = 8'hC4;
    localparam logic [7:0] MARK_JPG     = 8'hC8;
    localparam logic [7:0] MARK_DAC     = 8'hCC;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SOI    = 3'd1,
        ST_NO_FF     = 3'd2,
        ST_SHORT_LEN = 3'd3,
        ST_TRUNC     = 3'd4
    } status_t;

    typedef struct packed {
        logic        found;
        status_t     status;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } result_t;

    localparam int OUT_TDATA_W = 40;

endpackage

### src/jfsp_parse_core.sv
// ---------------------------------------------------------------------------
// jfsp_parse_core
// segment walker: holds parser state and decides the result for one byte
// ---------------------------------------------------------------------------
module jfsp_parse_core
    import jfsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        res_valid,
    output result_t     res
);

    typedef enum logic [2:0] {
        PH_SOI0,
        PH_SOI1,
        PH_HDR,
        PH_SKIP,
        PH_SOF,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic [15:0] skip_reg, skip_next;
    logic [7:0]  lead_reg, lead_next;
    logic [7:0]  marker_reg, marker_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] width_reg, width_next;

    logic        is_sof;
    logic [15:0] seg_len;
    logic [15:0] skip_dec;
    logic        hit;
    result_t     hit_res;

    assign is_sof = (marker_reg >= SOF_LOW) && (marker_reg <= SOF_HIGH)
                    && (marker_reg != MARK_DHT) && (marker_reg != MARK_JPG)
                    && (marker_reg != MARK_DAC);
    assign seg_len  = {len_hi_reg, data_byte};
    assign skip_dec = skip_reg - 16'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        skip_next   = skip_reg;
        lead_next   = lead_reg;
        marker_next = marker_reg;
        len_hi_next = len_hi_reg;
        height_next = height_reg;
        width_next  = width_reg;
        hit         = 1'b0;
        hit_res     = '{found: 1'b0, status: ST_OK, image_width: 16'd0,
                        image_height: 16'd0};

        case (phase_reg)
            PH_SOI0:
            begin
                if (data_byte == MARK_LEAD)
                begin
                    phase_next = PH_SOI1;
                end
                else
                begin
                    hit            = 1'b1;
                    hit_res.status = ST_NO_SOI;
                    phase_next     = PH_DONE;
                end
            end
            PH_SOI1:
            begin
                if (data_byte == MARK_SOI)
                begin
                    phase_next = PH_HDR;
                    pos_next   = 3'd0;
                end
                else
                begin
                    hit            = 1'b1;
                    hit_res.status = ST_NO_SOI;
                    phase_next     = PH_DONE;
                end
            end
            PH_HDR:
            begin
                case (pos_reg)
                    3'd0:
                    begin
                        lead_next = data_byte;
                        pos_next  = 3'd1;
                    end
                    3'd1:
                    begin
                        marker_next = data_byte;
                        pos_next    = 3'd2;
                    end
                    3'd2:
                    begin
                        len_hi_next = data_byte;
                        pos_next    = 3'd3;
                    end
                    default:
                    begin
                        pos_next = 3'd0;
                        if (lead_reg != MARK_LEAD)
                        begin
                            hit            = 1'b1;
                            hit_res.status = ST_NO_FF;
                            phase_next     = PH_DONE;
                        end
                        else if (is_sof)
                        begin
                            phase_next = PH_SOF;
                        end
                        else if (seg_len < 16'd2)
                        begin
                            hit            = 1'b1;
                            hit_res.status = ST_SHORT_LEN;
                            phase_next     = PH_DONE;
                        end
                        else if (seg_len != 16'd2)
                        begin
                            skip_next  = seg_len - 16'd2;
                            phase_next = PH_SKIP;
                        end
                    end
                endcase
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    phase_next = PH_HDR;
                    pos_next   = 3'd0;
                end
            end
            PH_SOF:
            begin
                case (pos_reg)
                    3'd0:
                    begin
                        pos_next = 3'd1;
                    end
                    3'd1:
                    begin
                        height_next = {data_byte, 8'd0};
                        pos_next    = 3'd2;
                    end
                    3'd2:
                    begin
                        height_next = {height_reg[15:8], data_byte};
                        pos_next    = 3'd3;
                    end
                    3'd3:
                    begin
                        width_next = {data_byte, 8'd0};
                        pos_next   = 3'd4;
                    end
                    default:
                    begin
                        width_next           = {width_reg[15:8], data_byte};
                        hit                  = 1'b1;
                        hit_res.found        = 1'b1;
                        hit_res.status       = ST_OK;
                        hit_res.image_width  = {width_reg[15:8], data_byte};
                        hit_res.image_height = height_reg;
                        phase_next           = PH_DONE;
                        pos_next             = 3'd0;
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        // end of file: report an early end, then start over
        if (last_byte)
        begin
            if (!hit && phase_next != PH_DONE)
            begin
                hit            = 1'b1;
                hit_res.status = (phase_next == PH_SOI0 || phase_next == PH_SOI1)
                                 ? ST_NO_SOI : ST_TRUNC;
            end
            phase_next  = PH_SOI0;
            pos_next    = 3'd0;
            skip_next   = 16'd0;
            lead_next   = 8'd0;
            marker_next = 8'd0;
            len_hi_next = 8'd0;
            height_next = 16'd0;
            width_next  = 16'd0;
        end
    end

    assign res_valid = hit;
    assign res       = hit_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SOI0;
            pos_reg    <= 3'd0;
            skip_reg   <= 16'd0;
            lead_reg   <= 8'd0;
            marker_reg <= 8'd0;
            len_hi_reg <= 8'd0;
            height_reg <= 16'd0;
            width_reg  <= 16'd0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            skip_reg   <= skip_next;
            lead_reg   <= lead_next;
            marker_reg <= marker_next;
            len_hi_reg <= len_hi_next;
            height_reg <= height_next;
            width_reg  <= width_next;
        end
    end

endmodule

### src/jfsp_out_reg.sv
// ---------------------------------------------------------------------------
// jfsp_out_reg
// result register on the master side, frees while the receiver takes it
// ---------------------------------------------------------------------------
module jfsp_out_reg
    import jfsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  result_t                res,
    output logic                   slot_free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser
);

    logic    valid_reg;
    result_t res_reg;

    assign slot_free = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.found;
    assign m_tdata  = {5'd0, res_reg.image_height, res_reg.image_width,
                       res_reg.status};

endmodule

### src/jpeg_frame_size_parser.sv
// ---------------------------------------------------------------------------
// jpeg_frame_size_parser
// finds the frame dimensions in a jpeg byte stream
// ---------------------------------------------------------------------------
// usage:
//   slave side takes one file byte per request in s_tdata, s_tlast on the
//   final byte of the file. master side gives at most one result per file:
//   the dimensions from the first start-of-frame header, or an error status
//   (no start-of-image, missing ff, length below two, truncated).
// path: a byte that causes a result lands in the input register, and the
//   result register loads that result when it takes the byte from there
//   (only while the result register is free), raising m_tvalid.
// throughput: one byte per cycle unless a result waits with m_tready low;
//   the single state update between the two registers sets that figure.
// stall: while a result waits in the result register and m_tready is low,
//   the input register holds its byte and s_tready drops once it is full;
//   bytes that give no result still pass only behind that waiting byte.
// reset: rst_n clears the parser to expect the start-of-image pair and
//   empties both registers. the final byte of a file also resets the parser.
// ---------------------------------------------------------------------------
module jpeg_frame_size_parser
    import jfsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // data_byte[7:0]
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // status[2:0], image_width[18:3],
                                              // image_height[34:19], zero fill
    output logic                   m_tuser    // found
);

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       slot_free;
    logic       step_en;
    logic       res_valid;
    result_t    res;

    assign step_en  = in_valid_reg && slot_free;
    assign s_tready = !in_valid_reg || slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    jfsp_parse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    jfsp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step_en && res_valid),
        .res       (res),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
